[design/lpc_pkg.sv]
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants for the LED power level and pulse controller:
// the input and output words, the sequencer states and the divider interface.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

  // Supply check period in ticks (the check fires every period plus one ticks)
  localparam int SAMPLE_PERIOD = 1024;

  // Sample counter reload after reset, level change or mode change
  localparam int RELOAD_COUNT  = 1000;
  localparam int CNT_MAX       = (SAMPLE_PERIOD + 1 > RELOAD_COUNT) ?
                                 (SAMPLE_PERIOD + 1) : RELOAD_COUNT;
  localparam int CNT_W         = $clog2(CNT_MAX + 1);

  // Supply decivolts numerator and quotient width
  localparam int VCC_NUMERATOR = 'h2160;
  localparam int QUO_W         = $clog2(VCC_NUMERATOR + 1);
  localparam int STEP_W        = $clog2(QUO_W);

  // Configuration register indexes
  localparam logic REG_REMOTE_ADDR = 1'b0;
  localparam logic REG_LOW_SUPPLY  = 1'b1;

  localparam logic [7:0] LOW_SUPPLY_RESET = 8'd34;

  // Remote command nibbles
  localparam logic [3:0] CMD_A = 4'h8;
  localparam logic [3:0] CMD_B = 4'h4;
  localparam logic [3:0] CMD_C = 4'h2;
  localparam logic [3:0] CMD_D = 4'h1;

  localparam logic [3:0] DEBOUNCE_TICKS = 4'd10;
  localparam logic [2:0] LEVEL_OFF      = 3'd6;
  localparam logic [8:0] PHASE_STEP     = 9'd11;
  localparam logic [9:0] PHASE_WRAP     = 10'd360;

  typedef struct packed {
    logic [23:0] radio_word;
    logic [7:0]  supply_sample;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [2:0] level_now;
    logic       pulsing_now;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[design/lpc_div.sv]
// ----------------------------------------------------------------------------
// lpc_div
// Restoring divider of the fixed supply numerator by an 8-bit sample, one
// quotient bit per cycle through a single compare and subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lpc_pkg::div_req_t req,
  output lpc_pkg::div_rsp_t      rsp
);

  localparam logic [lpc_pkg::QUO_W-1:0] NUM = lpc_pkg::QUO_W'(lpc_pkg::VCC_NUMERATOR);

  logic                          busy;
  logic                          done;
  logic [lpc_pkg::STEP_W-1:0]    step;
  logic [7:0]                    divisor;
  logic [7:0]                    rem;
  logic [lpc_pkg::QUO_W-1:0]     quo;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       ge;

  // Shift in the next numerator bit and try the subtract
  always_comb begin
    trial = {rem, NUM[step]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // Control: start loads, each step counts down, done pulses after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (step == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= '0;
      step    <= lpc_pkg::STEP_W'(lpc_pkg::QUO_W - 1);
    end else if (busy) begin
      rem  <= ge ? diff[7:0] : trial[7:0];
      quo  <= {quo[lpc_pkg::QUO_W-2:0], ge};
      step <= step - 1'b1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

[design/led_power_level_pulse_controller_unit.sv]
// ----------------------------------------------------------------------------
// led_power_level_pulse_controller_unit
// Per-tick LED controller: supply check, power level dimming, pulsing
// animation and remote command handling. One result word per input word.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | to block  | in_valid/in_stall  | lpc_pkg::in_word_t
//   out     | from block| out_valid/out_stall| lpc_pkg::out_word_t
//   cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data[23:0]
//
// A word passes through accept and finish. On ticks that run a supply check
// on a nonzero sample, the bit-serial divider works in between: 14 steps of
// one quotient bit each, then its done flag is seen in ST_DIV.
// rst is synchronous: all state returns to level 0, normal mode, phase 0,
// counter 1000, and the output register empties.
// A new word is taken while a finished word still waits on out_stall; the
// finish step then holds until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module led_power_level_pulse_controller_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire lpc_pkg::in_word_t   in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      lpc_pkg::out_word_t  out_data,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [23:0]         cfg_data
);

  localparam int CW = lpc_pkg::CNT_W;

  // Configuration
  logic [23:0] remote_addr;
  logic [7:0]  low_supply;

  // Tick state
  lpc_pkg::state_t   state, state_next;
  logic [2:0]        level, level_next;
  logic              pulsing, pulsing_next;
  logic [8:0]        phase, phase_next;
  logic [3:0]        debounce, debounce_next;
  logic [CW-1:0]     counter, counter_next;
  lpc_pkg::in_word_t item;

  lpc_pkg::div_req_t div_req;
  lpc_pkg::div_rsp_t div_rsp;
  lpc_pkg::out_word_t result;

  logic          accept;
  logic          fin_fire;
  logic          check;
  logic          need_div_in;
  logic          low_hit;
  logic [CW-1:0] cnt_inc;
  logic [2:0]    level_chk;
  logic [8:0]    phase_adv;
  logic [CW-1:0] counter_mid;
  logic          run;
  logic          addr_hit;
  logic [3:0]    cmd;
  logic [7:0]    red, green, blue;

  // Fold a sum below twice the wrap back into 0..359
  function automatic logic [8:0] wrap360(input logic [9:0] x);
    logic [9:0] y;
    begin
      y = (x >= lpc_pkg::PHASE_WRAP) ? (x - lpc_pkg::PHASE_WRAP) : x;
      wrap360 = y[8:0];
    end
  endfunction

  // Triangle pulse of one channel at angle a (0..359)
  function automatic logic [7:0] pulse(input logic [7:0] c, input logic [8:0] a);
    logic [8:0] v;
    logic [8:0] t;
    logic [8:0] sub;
    begin
      v = {c, 1'b0};
      t = (a >= 9'd120) ? (9'd240 - a) : a;
      sub = {t[7:0], 1'b0};
      if (a < 9'd240) begin
        v = (v > sub) ? (v - sub) : 9'd0;
      end
      pulse = (v > 9'd255) ? 8'd255 : v[7:0];
    end
  endfunction

  lpc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Supply check decision from the stored counter
  always_comb begin
    cnt_inc     = counter + 1'b1;
    run         = (level < lpc_pkg::LEVEL_OFF);
    check       = run && (cnt_inc > CW'(lpc_pkg::SAMPLE_PERIOD));
    need_div_in = check && (in_data.supply_sample != 8'd0);
    low_hit     = check && (item.supply_sample != 8'd0) &&
                  (div_rsp.quotient < lpc_pkg::QUO_W'(low_supply));
  end

  // Tick update: supply check, pulse, dim, then remote commands
  always_comb begin
    level_chk    = level + {2'b00, low_hit};
    phase_adv    = (run && pulsing) ? wrap360({1'b0, phase} + {1'b0, lpc_pkg::PHASE_STEP})
                                    : phase;
    counter_mid  = run ? (check ? '0 : cnt_inc) : counter;

    red   = item.color_red;
    green = item.color_green;
    blue  = item.color_blue;
    if (run && pulsing) begin
      red   = pulse(item.color_red, phase_adv);
      green = pulse(item.color_green, wrap360({1'b0, phase_adv} + 10'd120));
      blue  = pulse(item.color_blue, wrap360({1'b0, phase_adv} + 10'd240));
    end
    if (level_chk > 3'd1) blue = 8'd0;
    else if (level_chk > 3'd0) blue = blue >> 1;
    if (level_chk > 3'd3) green = 8'd0;
    else if (level_chk > 3'd2) green = green >> 1;
    if (level_chk > 3'd5) red = 8'd0;
    else if (level_chk > 3'd4) red = red >> 1;

    level_next    = level_chk;
    counter_next  = counter_mid;
    debounce_next = debounce;
    pulsing_next  = pulsing;
    phase_next    = phase_adv;
    addr_hit      = (item.radio_word[23:4] == remote_addr[23:4]);
    cmd           = item.radio_word[3:0];

    if (debounce == 4'd0) begin
      if (addr_hit) begin
        case (cmd)
          lpc_pkg::CMD_A: begin
            if (level_chk > 3'd0) begin
              counter_next = CW'(lpc_pkg::RELOAD_COUNT);
              level_next   = level_chk - 1'b1;
            end
            debounce_next = lpc_pkg::DEBOUNCE_TICKS;
          end
          lpc_pkg::CMD_B: begin
            if (level_chk < lpc_pkg::LEVEL_OFF) begin
              counter_next = CW'(lpc_pkg::RELOAD_COUNT);
              level_next   = level_chk + 1'b1;
            end
            debounce_next = lpc_pkg::DEBOUNCE_TICKS;
          end
          lpc_pkg::CMD_C: pulsing_next = 1'b0;
          lpc_pkg::CMD_D: pulsing_next = 1'b1;
          default: ;
        endcase
      end
    end else begin
      debounce_next = debounce - 1'b1;
    end

    // Mode change restarts the animation and the counter
    if (pulsing_next != pulsing) begin
      counter_next = CW'(lpc_pkg::RELOAD_COUNT);
      phase_next   = '0;
    end

    result.pixel_red   = red;
    result.pixel_green = green;
    result.pixel_blue  = blue;
    result.level_now   = level_next;
    result.pulsing_now = pulsing_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lpc_pkg::ST_IDLE: begin
        if (in_valid) state_next = need_div_in ? lpc_pkg::ST_DIV : lpc_pkg::ST_FINISH;
      end
      lpc_pkg::ST_DIV: begin
        if (div_rsp.done) state_next = lpc_pkg::ST_FINISH;
      end
      lpc_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = lpc_pkg::ST_IDLE;
      end
      default: state_next = lpc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall        = (state != lpc_pkg::ST_IDLE);
    accept          = in_valid && (state == lpc_pkg::ST_IDLE);
    fin_fire        = (state == lpc_pkg::ST_FINISH) && (!out_valid || !out_stall);
    div_req.start   = accept && need_div_in;
    div_req.divisor = in_data.supply_sample;
    cfg_ready       = 1'b1;
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= lpc_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (accept) item <= in_data;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      remote_addr <= '0;
      low_supply  <= lpc_pkg::LOW_SUPPLY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpc_pkg::REG_REMOTE_ADDR: remote_addr <= cfg_data;
        lpc_pkg::REG_LOW_SUPPLY:  low_supply  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Commit tick state at finish
  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      pulsing  <= 1'b0;
      phase    <= '0;
      debounce <= '0;
      counter  <= CW'(lpc_pkg::RELOAD_COUNT);
    end else if (fin_fire) begin
      level    <= level_next;
      pulsing  <= pulsing_next;
      phase    <= phase_next;
      debounce <= debounce_next;
      counter  <= counter_next;
    end
  end

  // Output register: load at finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) out_data <= result;
  end

  // Checks
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= lpc_pkg::LEVEL_OFF)
    else $error("power level out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase < 9'd360)
    else $error("animation phase out of range");

  a_debounce_range: assert property (@(posedge clk) disable iff (rst)
    debounce <= lpc_pkg::DEBOUNCE_TICKS)
    else $error("debounce count out of range");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == lpc_pkg::ST_FINISH)
    else $error("result word appeared outside finish");

  a_short_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && !need_div_in) |=> state == lpc_pkg::ST_FINISH)
    else $error("tick without supply check did not go to finish");

endmodule

`default_nettype wire

[test/tb_led_power_level_pulse_controller_unit.sv]
// ----------------------------------------------------------------------------
// tb_led_power_level_pulse_controller_unit
// Self-checking bench for the LED power level and pulse controller. A short
// stimulus table opens the run, then random phases follow, each with its own
// register settings and its own sender and receiver idling. A tick-accurate
// model of the controller predicts every result word, and a monitor checks
// each accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_led_power_level_pulse_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PLAN          = 18;
  localparam int N_PHASES        = 5;
  localparam int WORDS_PER_PHASE = 326;
  localparam int HOLD_CYCLES     = 400;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  lpc_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  lpc_pkg::out_word_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [23:0]        cfg_data;

  led_power_level_pulse_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus table: one input word per row, with a hand-written result where
  // it is obvious (right after reset, extreme colors)
  typedef struct {
    logic [23:0]        word;
    logic [7:0]         supply;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    bit                 exact;
    lpc_pkg::out_word_t want;
  } plan_row_t;

  plan_row_t plan [N_PLAN] = '{
    // idle word after reset: full white, level 0
    '{24'h000000, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1, {8'hff, 8'hff, 8'hff, 3'd0, 1'b0}},
    // command B: black pixel, level steps to 1, debounce armed
    '{24'h000004, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 8'h00, 8'h00, 3'd1, 1'b0}},
    // command A swallowed by debounce; blue halved at level 1
    '{24'h000008, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1, {8'hff, 8'hff, 8'h7f, 3'd1, 1'b0}},
    '{24'hffffff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, {8'hff, 8'hff, 8'h7f, 3'd1, 1'b0}},
    '{24'h000001, 8'h01, 8'h80, 8'h01, 8'hfe, 1'b0, '0},
    '{24'h800000, 8'h80, 8'h01, 8'h80, 8'hff, 1'b0, '0},
    '{24'h00000f, 8'h7f, 8'h7f, 8'h00, 8'h80, 1'b0, '0},
    '{24'h555555, 8'haa, 8'haa, 8'h55, 8'h01, 1'b0, '0},
    '{24'haaaaaa, 8'h55, 8'h55, 8'haa, 8'h02, 1'b0, '0},
    '{24'h000002, 8'h10, 8'h10, 8'h20, 8'h40, 1'b0, '0},
    '{24'h000004, 8'h20, 8'hfe, 8'hfd, 8'hfc, 1'b0, '0},
    '{24'h000008, 8'h40, 8'h00, 8'hff, 8'h00, 1'b0, '0},
    // debounce expired: D selects pulsing, then a pulsed tick
    '{24'h000001, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0, '0},
    '{24'h000000, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, '0},
    // unknown command nibble: no effect, no debounce
    '{24'h000003, 8'h00, 8'hc0, 8'h40, 8'h80, 1'b0, '0},
    // C back to normal, A to level 0, then B inside the debounce
    '{24'h000002, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0, '0},
    '{24'h000008, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0, '0},
    '{24'h000004, 8'hff, 8'h12, 8'h34, 8'h56, 1'b0, '0}
  };

  int phase_idle  [N_PHASES] = '{0, 76, 0, 22, 0};
  int phase_stall [N_PHASES] = '{0, 0, 76, 22, 10};

  // Controller model state and registers
  logic [2:0]  lvl_m;
  logic        pulse_m;
  int          phase_m;
  logic [3:0]  deb_m;
  int          cnt_m;
  logic [23:0] code_m;
  logic [7:0]  thr_m;

  lpc_pkg::out_word_t pixel_due_q [$];
  bit                 exact_now;
  lpc_pkg::out_word_t exact_want;

  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  bit favor_up;
  int quiet_left;

  int fails;
  int words_in;
  int words_out;
  int supply_checks;
  int supply_raises;
  int shut_seen;
  int pulse_seen;
  int reg_writes;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void restart_model();
    lvl_m   = 3'd0;
    pulse_m = 1'b0;
    phase_m = 0;
    deb_m   = 4'd0;
    cnt_m   = lpc_pkg::RELOAD_COUNT;
    code_m  = 24'h0;
    thr_m   = lpc_pkg::LOW_SUPPLY_RESET;
  endfunction

  // Triangle phase shift of one channel: 2c minus twice the triangle, clamped
  function automatic int pulse_shape(int c, int ph);
    int v;
    int a;
    v = 2 * c;
    a = ph % int'(lpc_pkg::PHASE_WRAP);
    if (a < 240) begin
      if (a >= 120) a = 240 - a;
      v = v - 2 * a;
      if (v < 0) v = 0;
    end
    if (v > 255) v = 255;
    return v;
  endfunction

  // Advance the controller by one tick and return its result word
  function automatic lpc_pkg::out_word_t tick_controller(lpc_pkg::in_word_t w);
    lpc_pkg::out_word_t o;
    int                 r;
    int                 g;
    int                 b;
    int                 dv;
    int                 lv;
    logic               next_pulse;
    r = int'(w.color_red);
    g = int'(w.color_green);
    b = int'(w.color_blue);
    next_pulse = pulse_m;
    if (lvl_m < lpc_pkg::LEVEL_OFF) begin
      cnt_m++;
      // supply check once every period plus one ticks
      if (cnt_m > lpc_pkg::SAMPLE_PERIOD) begin
        cnt_m = 0;
        supply_checks++;
        if (w.supply_sample != 8'd0) begin
          dv = lpc_pkg::VCC_NUMERATOR / int'(w.supply_sample);
          if (dv < int'(thr_m)) begin
            lvl_m++;
            supply_raises++;
          end
        end
      end
      if (pulse_m) begin
        phase_m = (phase_m + int'(lpc_pkg::PHASE_STEP)) % int'(lpc_pkg::PHASE_WRAP);
        r = pulse_shape(r, phase_m);
        g = pulse_shape(g, phase_m + 120);
        b = pulse_shape(b, phase_m + 240);
      end
      // dim blue, then green, then red
      lv = int'(lvl_m);
      if (lv > 1) b = 0; else if (lv > 0) b = b >> 1;
      if (lv > 3) g = 0; else if (lv > 2) g = g >> 1;
      if (lv > 5) r = 0; else if (lv > 4) r = r >> 1;
    end else begin
      r = 0;
      g = 0;
      b = 0;
    end
    // remote commands, gated by the debounce
    if (deb_m == 4'd0) begin
      if (w.radio_word[23:4] == code_m[23:4]) begin
        case (w.radio_word[3:0])
          lpc_pkg::CMD_A: begin
            if (lvl_m > 3'd0) begin
              cnt_m = lpc_pkg::RELOAD_COUNT;
              lvl_m--;
            end
            deb_m = lpc_pkg::DEBOUNCE_TICKS;
          end
          lpc_pkg::CMD_B: begin
            if (lvl_m < lpc_pkg::LEVEL_OFF) begin
              cnt_m = lpc_pkg::RELOAD_COUNT;
              lvl_m++;
            end
            deb_m = lpc_pkg::DEBOUNCE_TICKS;
          end
          lpc_pkg::CMD_C: next_pulse = 1'b0;
          lpc_pkg::CMD_D: next_pulse = 1'b1;
          default: ;
        endcase
      end
    end else begin
      deb_m--;
    end
    if (next_pulse != pulse_m) begin
      cnt_m   = lpc_pkg::RELOAD_COUNT;
      pulse_m = next_pulse;
      phase_m = 0;
    end
    o.pixel_red   = 8'(r);
    o.pixel_green = 8'(g);
    o.pixel_blue  = 8'(b);
    o.level_now   = lvl_m;
    o.pulsing_now = pulse_m;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR result %0d %s: got %0d, expected %0d", words_out, what, got, want);
    fails++;
  endtask

  // Random low nibble that is none of the four commands
  function automatic logic [3:0] odd_nibble();
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    while (n == lpc_pkg::CMD_A || n == lpc_pkg::CMD_B ||
           n == lpc_pkg::CMD_C || n == lpc_pkg::CMD_D)
      n = 4'($urandom_range(0, 15));
    return n;
  endfunction

  // Radio words: quiet stretches of noise broken by addressed commands
  function automatic logic [23:0] pick_radio_word();
    logic [23:0] w;
    int          roll;
    if (quiet_left > 0) begin
      quiet_left--;
      roll = int'($urandom_range(0, 9));
      if (roll < 4) begin
        w = 24'h0;
      end else if (roll < 6) begin
        w = {code_m[23:4], odd_nibble()};
      end else begin
        w = 24'($urandom());
        if (w[23:4] == code_m[23:4]) w[4] = ~w[4];
      end
    end else begin
      // long quiet stretches let the supply check come around
      if ($urandom_range(0, 4) == 0) quiet_left = int'($urandom_range(25, 60));
      else quiet_left = int'($urandom_range(0, 12));
      roll = int'($urandom_range(0, 99));
      if (roll < 20) w = {code_m[23:4], favor_up ? lpc_pkg::CMD_A : lpc_pkg::CMD_B};
      else if (roll < 70) w = {code_m[23:4], favor_up ? lpc_pkg::CMD_B : lpc_pkg::CMD_A};
      else if (roll < 82) w = {code_m[23:4], lpc_pkg::CMD_C};
      else if (roll < 94) w = {code_m[23:4], lpc_pkg::CMD_D};
      else w = {code_m[23:4], odd_nibble()};
    end
    return w;
  endfunction

  function automatic logic [7:0] pick_supply();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 20) return 8'h00;
    if (roll < 55) return 8'($urandom_range(240, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_color();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one word, with random idle cycles in front, and hold until taken
  task automatic drive_word(input lpc_pkg::in_word_t w, input bit exact,
                            input lpc_pkg::out_word_t want);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_data    = w;
    exact_now  = exact;
    exact_want = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pixel_due_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == lpc_pkg::REG_REMOTE_ADDR) code_m = val;
    else thr_m = val[7:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: random stall, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Monitor: check results first, then predict the word taken at this edge
  always @(posedge clk) begin
    lpc_pkg::out_word_t due;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pixel_due_q.size() == 0) begin
          report_mismatch("word with nothing pending, level", int'(out_data.level_now), -1);
        end else begin
          due = pixel_due_q.pop_front();
          if (out_data.pixel_red !== due.pixel_red)
            report_mismatch("pixel_red", int'(out_data.pixel_red), int'(due.pixel_red));
          if (out_data.pixel_green !== due.pixel_green)
            report_mismatch("pixel_green", int'(out_data.pixel_green), int'(due.pixel_green));
          if (out_data.pixel_blue !== due.pixel_blue)
            report_mismatch("pixel_blue", int'(out_data.pixel_blue), int'(due.pixel_blue));
          if (out_data.level_now !== due.level_now)
            report_mismatch("level_now", int'(out_data.level_now), int'(due.level_now));
          if (out_data.pulsing_now !== due.pulsing_now)
            report_mismatch("pulsing_now", int'(out_data.pulsing_now), int'(due.pulsing_now));
          if (due.level_now == lpc_pkg::LEVEL_OFF) shut_seen++;
          if (due.pulsing_now) pulse_seen++;
        end
        words_out++;
      end
      if (in_valid && !in_stall) begin
        due = tick_controller(in_data);
        pixel_due_q.push_back(exact_now ? exact_want : due);
        words_in++;
      end
    end
  end

  // Main sequence
  initial begin
    lpc_pkg::in_word_t w;
    logic [23:0]       code_v;
    logic [7:0]        thr_v;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = lpc_pkg::REG_REMOTE_ADDR;
    cfg_data   = 24'h0;
    exact_now  = 1'b0;
    exact_want = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    hold_left  = 0;
    favor_up   = 1'b1;
    quiet_left = 0;
    restart_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // walk the stimulus table at reset register values
    for (int i = 0; i < N_PLAN; i++) begin
      w = {plan[i].word, plan[i].supply, plan[i].red, plan[i].green, plan[i].blue};
      drive_word(w, plan[i].exact, plan[i].want);
    end
    settle_block();

    // random phases, each with fresh settings while the block is idle
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: code_v = 24'hffffff;
        1: code_v = 24'h000000;
        default: code_v = 24'($urandom());
      endcase
      case (p)
        0: thr_v = 8'd255;
        1: thr_v = 8'd0;
        2: thr_v = 8'd34;
        3: thr_v = 8'($urandom_range(1, 254));
        default: thr_v = lpc_pkg::LOW_SUPPLY_RESET;
      endcase
      write_reg(lpc_pkg::REG_REMOTE_ADDR, code_v);
      write_reg(lpc_pkg::REG_LOW_SUPPLY, {16'h0, thr_v});
      @(posedge clk);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      favor_up  = (p % 2 == 0);
      if (p == N_PHASES - 1) hold_req = 1'b1;
      repeat (WORDS_PER_PHASE) begin
        w.radio_word    = pick_radio_word();
        w.supply_sample = pick_supply();
        w.color_red     = pick_color();
        w.color_green   = pick_color();
        w.color_blue    = pick_color();
        drive_word(w, 1'b0, '0);
      end
      stall_pct = 0;
      settle_block();
    end

    // let any stray word show up before closing
    repeat (20) @(negedge clk);
    if (pixel_due_q.size() != 0)
      report_mismatch("words still pending at end", pixel_due_q.size(), 0);

    $display("Run: %0d words in, %0d results checked, %0d register writes",
             words_in, words_out, reg_writes);
    $display("Coverage: %0d supply checks (%0d raised level), %0d shutdown, %0d pulsing",
             supply_checks, supply_raises, shut_seen, pulse_seen);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
design/lpc_pkg.sv
design/lpc_div.sv
design/led_power_level_pulse_controller_unit.sv
test/tb_led_power_level_pulse_controller_unit.sv
